/* rtl/sbcm_pkg.sv */
// Shared types and constants for the sprite blitter with clipping and mirroring.
// Holds the configuration register codes and the result item layout.
// No dependencies.
package sbcm_pkg;

    localparam int SIZE_W     = 10;
    localparam int FRAME_W    = 11;
    localparam int HDR_W      = 4;
    localparam int VALUE_W    = 16;
    localparam int ADDR_W     = 20;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int PROD_W     = 2 * FRAME_W;

    localparam logic [SIZE_W-1:0]  SPRITE_SIZE_RESET = 10'd1;
    localparam logic [FRAME_W-1:0] FRAME_SIZE_RESET  = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SPRITE_WIDTH  = 3'd2,
        CFG_SPRITE_HEIGHT = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_FRAME_HEIGHT  = 3'd5,
        CFG_MIRROR_H      = 3'd6,
        CFG_HEADER_WORDS  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               image_done;
    } result_t;

endpackage

/* rtl/sprite_blit_clip_mirror.sv */
// Top level of the sprite blitter: header skip, position counters, mirror,
// clipping, color key and framebuffer address generation.
// Depends on sbcm_pkg.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    source_value, restart
// result    out        out_valid / out_ready  write_enable, write_address,
//                                             pixel_color, image_done
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per clock while in_ready is high; it waits in the item register, and its
// result is loaded into the result register, and offered, once that register has room.
// The item register feeds one pass of logic (clamp, mirror, clip and one
// 11 by 11 bit multiply for the address) into the result register.
// A stalled result holds the item register, and in_ready drops only when both hold items.
// Reset clears the counters and loads the register reset values; cfg_ready is always high.
module sprite_blit_clip_mirror #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sbcm_pkg::VALUE_W-1:0]      source_value,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              write_enable,
    output logic [sbcm_pkg::ADDR_W-1:0]       write_address,
    output logic [sbcm_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              image_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = CNT_W + 1;
    localparam int EXT_W = (DIM_W > sbcm_pkg::SIZE_W) ? DIM_W : sbcm_pkg::SIZE_W;
    localparam int SUM_W = ((CNT_W > sbcm_pkg::SIZE_W) ? CNT_W : sbcm_pkg::SIZE_W) + 1;
    localparam int CMP_W = (SUM_W > sbcm_pkg::FRAME_W) ? SUM_W : sbcm_pkg::FRAME_W;

    logic [sbcm_pkg::SIZE_W-1:0]  origin_x_reg;
    logic [sbcm_pkg::SIZE_W-1:0]  origin_y_reg;
    logic [sbcm_pkg::SIZE_W-1:0]  sprite_width_reg;
    logic [sbcm_pkg::SIZE_W-1:0]  sprite_height_reg;
    logic [sbcm_pkg::FRAME_W-1:0] frame_width_reg;
    logic [sbcm_pkg::FRAME_W-1:0] frame_height_reg;
    logic                         mirror_reg;
    logic [sbcm_pkg::HDR_W-1:0]   header_words_reg;

    logic [sbcm_pkg::HDR_W-1:0]   header_left_reg;
    logic [sbcm_pkg::HDR_W-1:0]   header_left_next;
    logic [CNT_W-1:0]             column_reg;
    logic [CNT_W-1:0]             column_next;
    logic [CNT_W-1:0]             row_reg;
    logic [CNT_W-1:0]             row_next;

    logic                         item_valid_reg;
    logic                         item_valid_next;
    logic [sbcm_pkg::VALUE_W-1:0] item_value_reg;
    logic                         item_restart_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    sbcm_pkg::result_t            result_reg;
    sbcm_pkg::result_t            result_next;

    logic                         in_fire;
    logic                         item_fire;
    logic                         out_space;

    logic [sbcm_pkg::HDR_W-1:0]   hdr_eff;
    logic [CNT_W-1:0]             col_eff;
    logic [CNT_W-1:0]             row_eff;
    logic [EXT_W-1:0]             sw_ext;
    logic [EXT_W-1:0]             sh_ext;
    logic [DIM_W-1:0]             w_eff;
    logic [DIM_W-1:0]             h_eff;
    logic [CNT_W-1:0]             w_last;
    logic [CNT_W-1:0]             h_last;
    logic [CNT_W-1:0]             col;
    logic [CNT_W-1:0]             row;
    logic [CNT_W-1:0]             col_dst;
    logic                         col_end;
    logic                         row_end;
    logic [CMP_W-1:0]             dx;
    logic [CMP_W-1:0]             dy;
    logic [sbcm_pkg::COLOR_W-1:0] color;
    logic                         visible;
    logic [sbcm_pkg::PROD_W-1:0]  addr_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            sprite_width_reg  <= sbcm_pkg::SPRITE_SIZE_RESET;
            sprite_height_reg <= sbcm_pkg::SPRITE_SIZE_RESET;
            frame_width_reg   <= sbcm_pkg::FRAME_SIZE_RESET;
            frame_height_reg  <= sbcm_pkg::FRAME_SIZE_RESET;
            mirror_reg        <= 1'b0;
            header_words_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sbcm_pkg::cfg_reg_t'(cfg_index))
                sbcm_pkg::CFG_ORIGIN_X:
                    origin_x_reg <= cfg_data[sbcm_pkg::SIZE_W-1:0];
                sbcm_pkg::CFG_ORIGIN_Y:
                    origin_y_reg <= cfg_data[sbcm_pkg::SIZE_W-1:0];
                sbcm_pkg::CFG_SPRITE_WIDTH:
                    sprite_width_reg <= cfg_data[sbcm_pkg::SIZE_W-1:0];
                sbcm_pkg::CFG_SPRITE_HEIGHT:
                    sprite_height_reg <= cfg_data[sbcm_pkg::SIZE_W-1:0];
                sbcm_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data;
                sbcm_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data;
                sbcm_pkg::CFG_MIRROR_H:
                    mirror_reg <= cfg_data[0];
                sbcm_pkg::CFG_HEADER_WORDS:
                    header_words_reg <= cfg_data[sbcm_pkg::HDR_W-1:0];
            endcase
        end
    end

    // Handshake: the item register advances whenever the result register has room.
    assign out_space = !out_valid_reg || out_ready;
    assign item_fire = item_valid_reg && out_space;
    assign in_ready  = !item_valid_reg || out_space;
    assign in_fire   = in_valid && in_ready;

    // Sprite size: zero acts as one and sizes above the counter range saturate.
    always_comb
    begin
        sw_ext = EXT_W'(sprite_width_reg);
        sh_ext = EXT_W'(sprite_height_reg);
        if (sw_ext == '0)
            w_eff = DIM_W'(1);
        else if (sw_ext > EXT_W'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = DIM_W'(sw_ext);
        if (sh_ext == '0)
            h_eff = DIM_W'(1);
        else if (sh_ext > EXT_W'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = DIM_W'(sh_ext);
        w_last = CNT_W'(w_eff - DIM_W'(1));
        h_last = CNT_W'(h_eff - DIM_W'(1));
    end

    always_comb
    begin
        hdr_eff = item_restart_reg ? header_words_reg : header_left_reg;
        col_eff = item_restart_reg ? '0 : column_reg;
        row_eff = item_restart_reg ? '0 : row_reg;

        col = (DIM_W'(col_eff) < w_eff) ? col_eff : w_last;
        row = (DIM_W'(row_eff) < h_eff) ? row_eff : h_last;
        col_end = (col == w_last);
        row_end = (row == h_last);

        col_dst = mirror_reg ? (w_last - col) : col;
        dx      = CMP_W'(origin_x_reg) + CMP_W'(col_dst);
        dy      = CMP_W'(origin_y_reg) + CMP_W'(row);
        color   = item_value_reg[sbcm_pkg::COLOR_W-1:0];
        visible = (dx < CMP_W'(frame_width_reg)) && (dy < CMP_W'(frame_height_reg))
                  && (color != '0);

        // Only the low eleven bits matter once the pixel lies inside the frame.
        addr_full = dy[sbcm_pkg::FRAME_W-1:0] * frame_width_reg
                    + sbcm_pkg::PROD_W'(dx[sbcm_pkg::FRAME_W-1:0]);

        header_left_next = header_left_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        result_next      = result_reg;

        if (item_fire)
        begin
            result_next = '0;
            if (hdr_eff != '0)
            begin
                header_left_next = hdr_eff - sbcm_pkg::HDR_W'(1);
                column_next      = col_eff;
                row_next         = row_eff;
            end
            else
            begin
                header_left_next = hdr_eff;
                if (visible)
                begin
                    result_next.write_enable  = 1'b1;
                    result_next.write_address = addr_full[sbcm_pkg::ADDR_W-1:0];
                    result_next.pixel_color   = color;
                end
                result_next.image_done = col_end && row_end;
                if (col_end)
                begin
                    column_next = '0;
                    row_next    = row_end ? '0 : row + CNT_W'(1);
                end
                else
                begin
                    column_next = col + CNT_W'(1);
                    row_next    = row;
                end
            end
        end

        if (in_fire)
            item_valid_next = 1'b1;
        else if (item_fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        if (item_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            header_left_reg <= header_left_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            item_valid_reg  <= item_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_value_reg   <= source_value;
            item_restart_reg <= restart;
        end
        result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = result_reg.write_enable;
    assign write_address = result_reg.write_address;
    assign pixel_color   = result_reg.pixel_color;
    assign image_done    = result_reg.image_done;

    // A result with no write carries a zero address and color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.write_enable |->
            result_reg.write_address == '0 && result_reg.pixel_color == '0)
        else $error("non-write result carries address or color");

    // A skipped header word produces an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && hdr_eff != '0 |=>
            out_valid_reg && !result_reg.write_enable && !result_reg.image_done)
        else $error("header word produced a write or end of image");

    // The end of the sprite wraps both counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && hdr_eff == '0 && col_end && row_end |=>
            column_reg == '0 && row_reg == '0 && result_reg.image_done)
        else $error("counters did not wrap at end of sprite");

    // Both stages full with the result stalled must block new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline is full and stalled");

endmodule

/* dv/tb_sprite_blit_clip_mirror.sv */
// Self-checking testbench for sprite_blit_clip_mirror: directed and random sprite words,
// register setups between phases, a built-in predictor and a per-field result check.
// Depends on sbcm_pkg and the sprite_blit_clip_mirror RTL.
module tb_sprite_blit_clip_mirror;

    localparam int MAX_DIM = 1024;

    typedef struct {
        logic [sbcm_pkg::VALUE_W-1:0] value;
        logic                         restart;
    } pixel_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [sbcm_pkg::VALUE_W-1:0]    source_value = '0;
    logic                            restart = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            write_enable;
    logic [sbcm_pkg::ADDR_W-1:0]     write_address;
    logic [sbcm_pkg::COLOR_W-1:0]    pixel_color;
    logic                            image_done;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sbcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sbcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pixel_word_t       pending_words[$];
    sbcm_pkg::result_t expected_writes[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int writes_seen = 0;
    int sprites_done = 0;
    int reg_writes = 0;

    logic [sbcm_pkg::SIZE_W-1:0]  blit_origin_x = '0;
    logic [sbcm_pkg::SIZE_W-1:0]  blit_origin_y = '0;
    logic [sbcm_pkg::SIZE_W-1:0]  blit_sprite_w = sbcm_pkg::SPRITE_SIZE_RESET;
    logic [sbcm_pkg::SIZE_W-1:0]  blit_sprite_h = sbcm_pkg::SPRITE_SIZE_RESET;
    logic [sbcm_pkg::FRAME_W-1:0] blit_frame_w = sbcm_pkg::FRAME_SIZE_RESET;
    logic [sbcm_pkg::FRAME_W-1:0] blit_frame_h = sbcm_pkg::FRAME_SIZE_RESET;
    logic                         blit_mirror = 1'b0;
    logic [sbcm_pkg::HDR_W-1:0]   blit_header_words = '0;

    logic [sbcm_pkg::HDR_W-1:0]   header_left = '0;
    logic [sbcm_pkg::SIZE_W-1:0]  src_col = '0;
    logic [sbcm_pkg::SIZE_W-1:0]  src_row = '0;

    sprite_blit_clip_mirror #(
        .MAX_DIM(MAX_DIM)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_value (source_value),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .write_address(write_address),
        .pixel_color  (pixel_color),
        .image_done   (image_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int clamp_dim(input logic [sbcm_pkg::SIZE_W-1:0] d);
        if (d == 0)
            return 1;
        if (int'(d) > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Computes the framebuffer write caused by one sprite word and advances the position.
    function automatic void blit_predict(input logic [sbcm_pkg::VALUE_W-1:0] value,
                                         input logic rst_pos);
        sbcm_pkg::result_t r;
        int w;
        int h;
        int col;
        int row;
        int dx;
        int dy;
        logic [sbcm_pkg::COLOR_W-1:0] color;
        r = '0;
        if (rst_pos)
        begin
            header_left = blit_header_words;
            src_col = '0;
            src_row = '0;
        end
        if (header_left != 0)
        begin
            header_left = header_left - 1'b1;
            expected_writes.push_back(r);
            return;
        end
        w = clamp_dim(blit_sprite_w);
        h = clamp_dim(blit_sprite_h);
        col = (int'(src_col) < w) ? int'(src_col) : w - 1;
        row = (int'(src_row) < h) ? int'(src_row) : h - 1;
        dx = int'(blit_origin_x) + (blit_mirror ? (w - 1 - col) : col);
        dy = int'(blit_origin_y) + row;
        color = value[sbcm_pkg::COLOR_W-1:0];
        if (dx < int'(blit_frame_w) && dy < int'(blit_frame_h) && color != 0)
        begin
            r.write_enable = 1'b1;
            r.write_address = sbcm_pkg::ADDR_W'(dy * int'(blit_frame_w) + dx);
            r.pixel_color = color;
        end
        r.image_done = (col + 1 >= w) && (row + 1 >= h);
        if (col + 1 >= w)
        begin
            src_col = '0;
            src_row = (row + 1 >= h) ? '0 : sbcm_pkg::SIZE_W'(row + 1);
        end
        else
        begin
            src_col = sbcm_pkg::SIZE_W'(col + 1);
            src_row = sbcm_pkg::SIZE_W'(row);
        end
        expected_writes.push_back(r);
    endfunction

    function automatic void apply_reg(input sbcm_pkg::cfg_reg_t idx,
                                      input logic [sbcm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            sbcm_pkg::CFG_ORIGIN_X:      blit_origin_x = data[sbcm_pkg::SIZE_W-1:0];
            sbcm_pkg::CFG_ORIGIN_Y:      blit_origin_y = data[sbcm_pkg::SIZE_W-1:0];
            sbcm_pkg::CFG_SPRITE_WIDTH:  blit_sprite_w = data[sbcm_pkg::SIZE_W-1:0];
            sbcm_pkg::CFG_SPRITE_HEIGHT: blit_sprite_h = data[sbcm_pkg::SIZE_W-1:0];
            sbcm_pkg::CFG_FRAME_WIDTH:   blit_frame_w = data[sbcm_pkg::FRAME_W-1:0];
            sbcm_pkg::CFG_FRAME_HEIGHT:  blit_frame_h = data[sbcm_pkg::FRAME_W-1:0];
            sbcm_pkg::CFG_MIRROR_H:      blit_mirror = data[0];
            sbcm_pkg::CFG_HEADER_WORDS:  blit_header_words = data[sbcm_pkg::HDR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [sbcm_pkg::CFG_DATA_W-1:0] pick_reg_value(
        input sbcm_pkg::cfg_reg_t idx);
        logic [sbcm_pkg::CFG_DATA_W-1:0] v;
        v = sbcm_pkg::CFG_DATA_W'($urandom_range(0, 2047));
        case (idx)
            sbcm_pkg::CFG_ORIGIN_X, sbcm_pkg::CFG_ORIGIN_Y:
                if ($urandom_range(0, 7) != 0)
                    v[sbcm_pkg::SIZE_W-1:0] = sbcm_pkg::SIZE_W'($urandom_range(0, 12));
            sbcm_pkg::CFG_SPRITE_WIDTH, sbcm_pkg::CFG_SPRITE_HEIGHT:
                if ($urandom_range(0, 9) != 0)
                    v[sbcm_pkg::SIZE_W-1:0] = sbcm_pkg::SIZE_W'($urandom_range(0, 6));
            sbcm_pkg::CFG_FRAME_WIDTH, sbcm_pkg::CFG_FRAME_HEIGHT:
                case ($urandom_range(0, 9))
                    0: v = 11'd0;
                    1: v = 11'd2047;
                    2: v = 11'd1024;
                    3: ;
                    default: v = sbcm_pkg::CFG_DATA_W'($urandom_range(1, 24));
                endcase
            sbcm_pkg::CFG_HEADER_WORDS:
                if ($urandom_range(0, 3) != 0)
                    v[sbcm_pkg::HDR_W-1:0] = sbcm_pkg::HDR_W'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic push_word(input logic [sbcm_pkg::VALUE_W-1:0] value, input logic rst_pos);
        pixel_word_t w;
        w.value = value;
        w.restart = rst_pos;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input sbcm_pkg::cfg_reg_t idx,
                             input logic [sbcm_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_random_setup();
        for (int i = 0; i < 8; i++)
            write_reg(sbcm_pkg::cfg_reg_t'(i), pick_reg_value(sbcm_pkg::cfg_reg_t'(i)));
    endtask

    task automatic push_random_words(input int count);
        logic [sbcm_pkg::VALUE_W-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            v = sbcm_pkg::VALUE_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 4) == 0)
                v[sbcm_pkg::COLOR_W-1:0] = '0;
            push_word(v, (i == 0) || ($urandom_range(0, 24) == 0));
        end
    endtask

    always @(posedge clk)
    begin : word_driver
        pixel_word_t nxt;
        if (in_valid && in_ready)
        begin
            blit_predict(source_value, restart);
            words_sent++;
        end
        if (in_valid && !in_ready)
        begin
        end
        else if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
        begin
            nxt = pending_words.pop_front();
            in_valid <= 1'b1;
            source_value <= nxt.value;
            restart <= nxt.restart;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : write_monitor
        sbcm_pkg::result_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (write_enable)
                writes_seen++;
            if (image_done)
                sprites_done++;
            if (expected_writes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got we=%0b addr=0x%0h color=0x%0h",
                         $time, write_enable, write_address, pixel_color);
                errors++;
            end
            else
            begin
                want = expected_writes.pop_front();
                check_field("write_enable", want.write_enable, write_enable);
                check_field("write_address", want.write_address, write_address);
                check_field("pixel_color", want.pixel_color, pixel_color);
                check_field("image_done", want.image_done, image_done);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #400000;
        $display("Run timed out waiting for results.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Reset setup: one-pixel sprite, transparent and opaque words.
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0100, 1'b1);
        push_word(16'h00FF, 1'b0);
        wait_drained();

        // Mirrored 4x2 sprite clipped on the right edge, with a two-word header.
        write_reg(sbcm_pkg::CFG_ORIGIN_X, 11'd14);
        write_reg(sbcm_pkg::CFG_ORIGIN_Y, 11'd3);
        write_reg(sbcm_pkg::CFG_SPRITE_WIDTH, 11'd4);
        write_reg(sbcm_pkg::CFG_SPRITE_HEIGHT, 11'd2);
        write_reg(sbcm_pkg::CFG_FRAME_WIDTH, 11'd16);
        write_reg(sbcm_pkg::CFG_FRAME_HEIGHT, 11'd4);
        write_reg(sbcm_pkg::CFG_MIRROR_H, 11'd1);
        write_reg(sbcm_pkg::CFG_HEADER_WORDS, 11'd2);
        push_word(16'hABCD, 1'b1);
        push_word(16'h1234, 1'b0);
        push_word(16'h0011, 1'b0);
        push_word(16'h8022, 1'b0);
        push_word(16'h7F00, 1'b0);
        push_word(16'h0144, 1'b0);
        push_word(16'hFF55, 1'b0);
        push_word(16'h0066, 1'b0);
        push_word(16'h0077, 1'b0);
        push_word(16'h0088, 1'b0);
        push_word(16'h0099, 1'b0);
        wait_drained();

        // Header count changes without restart, zero sizes and an empty frame.
        write_reg(sbcm_pkg::CFG_HEADER_WORDS, 11'd5);
        write_reg(sbcm_pkg::CFG_SPRITE_WIDTH, 11'd0);
        write_reg(sbcm_pkg::CFG_SPRITE_HEIGHT, 11'd0);
        write_reg(sbcm_pkg::CFG_FRAME_WIDTH, 11'd0);
        push_word(16'h00AA, 1'b0);
        wait_drained();

        // Largest origin and frame: the address wraps past its 20 bits.
        write_reg(sbcm_pkg::CFG_FRAME_WIDTH, 11'd2047);
        write_reg(sbcm_pkg::CFG_FRAME_HEIGHT, 11'd2047);
        write_reg(sbcm_pkg::CFG_ORIGIN_X, 11'd1023);
        write_reg(sbcm_pkg::CFG_ORIGIN_Y, 11'd1023);
        write_reg(sbcm_pkg::CFG_MIRROR_H, 11'd0);
        write_reg(sbcm_pkg::CFG_SPRITE_WIDTH, 11'd1023);
        write_reg(sbcm_pkg::CFG_SPRITE_HEIGHT, 11'd1023);
        push_word(16'h0077, 1'b1);
        for (int i = 0; i < 4; i++)
            push_word(16'h5A5A, 1'b0);
        push_word(16'h00C3, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h8001, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                wait_drained();
                load_random_setup();
                push_random_words(50);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_writes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_writes.size());
            errors++;
        end
        $display("Sent %0d sprite words under %0d register writes and four handshake phases.",
                 words_sent, reg_writes);
        $display("Checked %0d results: %0d framebuffer writes, %0d sprite ends.",
                 results_seen, writes_seen, sprites_done);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
